// File: rtl/facr_pkg.sv
// ----------------------------------------------------------------------------
// facr_pkg: shared types and constants for the flow color renderer
// Payload structs, command codes and the angle step table.
// ----------------------------------------------------------------------------
package facr_pkg;

  localparam logic [1:0] CMD_EVENT = 2'd0;
  localparam logic [1:0] CMD_TICK  = 2'd1;
  localparam logic [1:0] CMD_READ  = 2'd2;

  localparam logic REG_GAIN   = 1'b0;
  localparam logic REG_PERIOD = 1'b1;

  typedef struct packed {
    logic [1:0]         cmd;
    logic [6:0]         column;
    logic [6:0]         row;
    logic signed [15:0] vel_x;
    logic signed [15:0] vel_y;
  } in_item_t;

  typedef struct packed {
    logic       frame_due;
    logic [6:0] out_column;
    logic [6:0] out_row;
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
  } out_item_t;

  localparam int WHEEL_STEPS = 14;

  function automatic logic [14:0] wheel_step(input logic [3:0] i);
    logic [14:0] r;
    case (i)
      4'd0: r = 15'd24576;  4'd1: r = 15'd14508; 4'd2: r = 15'd7666;
      4'd3: r = 15'd3891;   4'd4: r = 15'd1953;  4'd5: r = 15'd978;
      4'd6: r = 15'd489;    4'd7: r = 15'd244;   4'd8: r = 15'd122;
      4'd9: r = 15'd61;     4'd10: r = 15'd31;   4'd11: r = 15'd15;
      4'd12: r = 15'd8;     4'd13: r = 15'd4;
      default: r = 15'd0;
    endcase
    return r;
  endfunction

endpackage

// File: rtl/facr_sum_ram.sv
// ----------------------------------------------------------------------------
// facr_sum_ram: per-pixel velocity sum memory
// One write port, one registered read port, both sums in one word.
// ----------------------------------------------------------------------------
module facr_sum_ram #(
  parameter int DEPTH = 16384,
  parameter int AW    = 14,
  parameter int DW    = 64
) (
  input  logic          clk,
  input  logic          wr_en,
  input  logic [AW-1:0] wr_addr,
  input  logic [DW-1:0] wr_data,
  input  logic [AW-1:0] rd_addr,
  output logic [DW-1:0] rd_data
);
  logic [DW-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end
endmodule

// File: rtl/facr_color.sv
// ----------------------------------------------------------------------------
// facr_color: sum to color-wheel mapping
// Sequential unit: gain multiply, length square root and divide (skipped for
// small vectors), angle rotation, sector blend. Takes a new sum only when idle.
// ----------------------------------------------------------------------------
module facr_color #(
  parameter int SW = 32
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  input  logic signed [SW-1:0] sum_x,
  input  logic signed [SW-1:0] sum_y,
  input  logic [15:0]          gain,
  output logic                 done,
  output logic [7:0]           red,
  output logic [7:0]           green,
  output logic [7:0]           blue
);
  import facr_pkg::*;

  localparam int PW = SW + 16;

  typedef enum logic [3:0] {
    S_IDLE, S_MUL, S_SHIFT, S_SQA, S_SQB, S_ROOT, S_DIVX, S_DIVY, S_MAG, S_MROOT,
    S_ROT, S_MIX, S_OUT
  } state_t;

  state_t      state_r;
  logic        neg_x_r, neg_y_r;
  logic [SW-1:0] abs_x_r, abs_y_r;
  logic [PW-1:0] ax_r, ay_r;
  logic [61:0] acc_r;
  logic [61:0] rem_r;
  logic [31:0] root_r;
  logic [5:0]  cnt_r;
  logic [41:0] num_r;
  logic [41:0] quo_r;
  logic [35:0] den_r;
  logic [6:0]  qx_r, qy_r;
  logic signed [24:0] cx_r, cy_r;
  logic signed [18:0] z_r, off_r;
  logic [7:0]  mag_r;
  logic [17:0] alfa_r;
  logic [1:0]  sect_r;
  logic [16:0] f_r;
  logic [7:0]  red_r, green_r, blue_r;
  logic        done_r;
  logic        white_r;

  // square-root step (restoring, two bits per iteration)
  logic [63:0] sq_try;
  assign sq_try = {root_r, 2'b01};
  logic [63:0] rem_sh;
  assign rem_sh = {rem_r[61:0], acc_r[61:60]};

  logic [42:0] div_diff;
  assign div_diff = {quo_r[41:0], num_r[41]} - {7'd0, den_r};

  logic signed [24:0] dx, dy;
  assign dx = cy_r >>> cnt_r[3:0];
  assign dy = cx_r >>> cnt_r[3:0];
  logic signed [24:0] dxt, dyt;
  assign dxt = (cy_r < 0 && (dx <<< cnt_r[3:0]) != cy_r) ? dx + 25'sd1 : dx;
  assign dyt = (cx_r < 0 && (dy <<< cnt_r[3:0]) != cx_r) ? dy + 25'sd1 : dy;

  logic signed [19:0] alfa_s;
  assign alfa_s = 20'sd98304 + 20'(off_r) + 20'(z_r);

  logic [24:0] mf, mg;
  assign mf = mag_r * f_r;
  assign mg = mag_r * (17'd65536 - f_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      done_r  <= 1'b0;
    end else begin
      done_r <= 1'b0;
      unique case (state_r)
        S_IDLE: begin
          if (start) begin
            neg_x_r <= sum_x[SW-1];
            neg_y_r <= sum_y[SW-1];
            abs_x_r <= sum_x[SW-1] ? SW'(-sum_x) : SW'(sum_x);
            abs_y_r <= sum_y[SW-1] ? SW'(-sum_y) : SW'(sum_y);
            white_r <= (sum_x == '0) && (sum_y == '0);
            state_r <= S_MUL;
          end
        end
        S_MUL: begin
          ax_r    <= PW'(abs_x_r) * PW'(gain);
          ay_r    <= PW'(abs_y_r) * PW'(gain);
          state_r <= white_r ? S_OUT : S_SHIFT;
        end
        S_SHIFT: begin
          if (ax_r < (PW'(128) << 16) && ay_r < (PW'(128) << 16)
              && 62'(ax_r[22:0]) * 62'(ax_r[22:0]) + 62'(ay_r[22:0]) * 62'(ay_r[22:0])
                 < (62'd1 << 46)) begin
            qx_r    <= ax_r[22:16];
            qy_r    <= ay_r[22:16];
            state_r <= S_MAG;
          end else if ((ax_r >> 30) != '0 || (ay_r >> 30) != '0) begin
            ax_r <= ax_r >> 1;
            ay_r <= ay_r >> 1;
          end else begin
            state_r <= S_SQA;
          end
        end
        S_SQA: begin
          acc_r   <= 62'(ax_r[29:0]) * 62'(ax_r[29:0]);
          state_r <= S_SQB;
        end
        S_SQB: begin
          acc_r   <= acc_r + 62'(ay_r[29:0]) * 62'(ay_r[29:0]);
          rem_r   <= '0;
          root_r  <= '0;
          cnt_r   <= 6'd30;
          state_r <= S_ROOT;
        end
        S_ROOT, S_MROOT: begin
          if (rem_sh >= sq_try) begin
            rem_r  <= 62'(rem_sh - sq_try);
            root_r <= {root_r[30:0], 1'b1};
          end else begin
            rem_r  <= rem_sh[61:0];
            root_r <= {root_r[30:0], 1'b0};
          end
          acc_r <= acc_r << 2;
          cnt_r <= cnt_r - 6'd1;
          if (cnt_r == '0) begin
            if (state_r == S_ROOT) begin
              state_r <= S_DIVX;
              num_r   <= 42'(ax_r[29:0]) * 42'd1279;
              quo_r   <= '0;
              den_r   <= 36'({root_r[30:0], (rem_sh >= sq_try)}) * 36'd10;
              cnt_r   <= 6'd41;
            end else begin
              mag_r   <= root_r[30:0] >= 31'd128 ? 8'd255
                       : {root_r[6:0], (rem_sh >= sq_try)};
              state_r <= S_ROT;
              cx_r    <= qx_r == 0 && neg_x_r ? '0 : 25'(qx_r) <<< 16;
              cy_r    <= neg_y_r ? -(25'(qy_r) <<< 16) : 25'(qy_r) <<< 16;
              z_r     <= '0;
              off_r   <= '0;
              cnt_r   <= '0;
            end
          end
        end
        // bit-serial restoring divide; quo_r holds the remainder, num_r shifts in quotient bits
        S_DIVX, S_DIVY: begin
          if (!div_diff[42]) begin
            quo_r <= div_diff[41:0];
            num_r <= {num_r[40:0], 1'b1};
          end else begin
            quo_r <= {quo_r[40:0], num_r[41]};
            num_r <= {num_r[40:0], 1'b0};
          end
          cnt_r <= cnt_r - 6'd1;
          if (cnt_r == '0) begin
            if (state_r == S_DIVX) begin
              qx_r    <= div_diff[42] ? {num_r[5:0], 1'b0} : {num_r[5:0], 1'b1};
              num_r   <= 42'(ay_r[29:0]) * 42'd1279;
              quo_r   <= '0;
              cnt_r   <= 6'd41;
              state_r <= S_DIVY;
            end else begin
              qy_r    <= div_diff[42] ? {num_r[5:0], 1'b0} : {num_r[5:0], 1'b1};
              state_r <= S_MAG;
            end
          end
        end
        // 4*(qx^2+qy^2) placed at the top of the root input
        S_MAG: begin
          acc_r   <= (62'(qx_r) * 62'(qx_r) + 62'(qy_r) * 62'(qy_r)) << 38;
          rem_r   <= '0;
          root_r  <= '0;
          cnt_r   <= 6'd12;
          state_r <= S_MROOT;
        end
        S_ROT: begin
          if (cnt_r == '0 && neg_x_r && qx_r != 0) begin
            // reflect into right half plane
            off_r <= (cy_r >= 0) ? 19'sd98304 : -19'sd98304;
            cy_r  <= -cy_r;
            cnt_r <= 6'd32;
          end else begin
            if (cy_r > 0) begin
              cx_r <= cx_r + dxt;
              cy_r <= cy_r - dyt;
              z_r  <= z_r + 19'(wheel_step(cnt_r[3:0]));
            end else begin
              cx_r <= cx_r - dxt;
              cy_r <= cy_r + dyt;
              z_r  <= z_r - 19'(wheel_step(cnt_r[3:0]));
            end
            cnt_r <= {2'b00, cnt_r[3:0] + 4'd1};
            if (cnt_r[3:0] == 4'(WHEEL_STEPS - 1)) begin
              state_r <= S_MIX;
            end
          end
        end
        S_MIX: begin
          if (alfa_s < 0) begin
            alfa_r <= '0;
          end else if (alfa_s > 20'sd196608) begin
            alfa_r <= 18'd196608;
          end else begin
            alfa_r <= alfa_s[17:0];
          end
          state_r <= S_OUT;
          sect_r  <= 2'd3;
        end
        S_OUT: begin
          if (white_r) begin
            red_r <= 8'd255; green_r <= 8'd255; blue_r <= 8'd255;
            done_r  <= 1'b1;
            state_r <= S_IDLE;
          end else if (sect_r == 2'd3) begin
            sect_r <= alfa_r < 18'd65536 ? 2'd0 : (alfa_r < 18'd131072 ? 2'd1 : 2'd2);
            f_r    <= alfa_r < 18'd65536 ? alfa_r[16:0]
                    : (alfa_r < 18'd131072 ? 17'(alfa_r - 18'd65536)
                                           : 17'(alfa_r - 18'd131072));
          end else begin
            unique case (sect_r)
              2'd0: begin
                red_r   <= 8'(255 - mag_r) + mf[23:16];
                green_r <= 8'(255 - mag_r) + mg[23:16];
                blue_r  <= 8'(255 - mag_r);
              end
              2'd1: begin
                red_r   <= 8'(255 - mag_r) + mg[23:16];
                green_r <= 8'(255 - mag_r);
                blue_r  <= 8'(255 - mag_r) + mf[23:16];
              end
              default: begin
                red_r   <= 8'(255 - mag_r);
                green_r <= 8'(255 - mag_r) + mf[23:16];
                blue_r  <= 8'(255 - mag_r) + mg[23:16];
              end
            endcase
            done_r  <= 1'b1;
            state_r <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign done  = done_r;
  assign red   = red_r;
  assign green = green_r;
  assign blue  = blue_r;
endmodule

// File: rtl/flow_accumulate_color_render.sv
// ----------------------------------------------------------------------------
// flow_accumulate_color_render: optical flow accumulator with color readout
//
//   channel | direction | handshake
//   in_     | input     | in_valid / in_stall
//   out_    | output    | out_valid / out_stall
//   cfg_    | input     | cfg_valid / cfg_ready
//
// Events and ticks pass through a memory read, then update and write back.
// A readout also runs facr_color, whose bit-serial root and divide are
// skipped for sums that stay inside the wheel.
// After reset a clearing pass over all COLUMNS*ROWS cells blocks requests.
// Output stalls hold the result register and the next request.
// ----------------------------------------------------------------------------
module flow_accumulate_color_render #(
  parameter int COLUMNS   = 128,
  parameter int ROWS      = 128,
  parameter int SUM_WIDTH = 32
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  facr_pkg::in_item_t in_data,
  output logic               out_valid,
  input  logic               out_stall,
  output facr_pkg::out_item_t out_data,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [0:0]         cfg_index,
  input  logic [23:0]        cfg_data
);
  import facr_pkg::*;

  localparam int CELLS = COLUMNS * ROWS;
  localparam int AW    = $clog2(CELLS);
  localparam int DW    = 2 * SUM_WIDTH;

  typedef enum logic [2:0] {S_CLEAR, S_IDLE, S_READ, S_UPD, S_COLOR, S_HOLD} state_t;

  state_t              state_r;
  logic [AW:0]         clr_r;
  logic [15:0]         gain_r;
  logic [23:0]         period_r;
  logic [23:0]         ticks_r;
  in_item_t            req_r;
  logic                inside_r;
  out_item_t           res_r;
  logic                res_valid_r;
  logic                wr_en;
  logic [AW-1:0]       wr_addr, rd_addr, addr_r;
  logic [DW-1:0]       wr_data, rd_data;
  logic                col_start, col_done;
  logic [7:0]          cr, cg, cb;

  logic signed [SUM_WIDTH-1:0] sx, sy;
  assign sx = rd_data[DW-1:SUM_WIDTH];
  assign sy = rd_data[SUM_WIDTH-1:0];

  function automatic logic signed [SUM_WIDTH-1:0] sat_add(
    input logic signed [SUM_WIDTH-1:0] s, input logic signed [15:0] v);
    logic signed [SUM_WIDTH:0] r;
    r = (SUM_WIDTH+1)'(s) + (SUM_WIDTH+1)'(v);
    if (r[SUM_WIDTH] != r[SUM_WIDTH-1]) begin
      return r[SUM_WIDTH] ? {1'b1, {(SUM_WIDTH-1){1'b0}}} : {1'b0, {(SUM_WIDTH-1){1'b1}}};
    end
    return r[SUM_WIDTH-1:0];
  endfunction

  // a waiting result may leave in the same cycle a new request comes in
  logic in_ok;
  assign in_ok    = (state_r == S_IDLE) && (!res_valid_r || !out_stall);
  assign in_stall = !in_ok;
  assign cfg_ready = 1'b1;

  logic inside_in;
  assign inside_in = 32'(in_data.column) < COLUMNS && 32'(in_data.row) < ROWS;
  // hold the request's address while it is in flight
  assign rd_addr = (state_r == S_IDLE)
                 ? AW'(32'(in_data.row) * COLUMNS + 32'(in_data.column)) : addr_r;

  always_comb begin
    wr_en   = 1'b0;
    wr_addr = addr_r;
    wr_data = '0;
    if (state_r == S_CLEAR) begin
      wr_en   = 1'b1;
      wr_addr = clr_r[AW-1:0];
    end else if (state_r == S_UPD && inside_r) begin
      if (req_r.cmd == CMD_EVENT) begin
        wr_en   = 1'b1;
        wr_data = {sat_add(sx, req_r.vel_x), sat_add(sy, req_r.vel_y)};
      end else if (req_r.cmd == CMD_READ) begin
        wr_en = 1'b1;
      end
    end
  end

  assign col_start = (state_r == S_UPD) && req_r.cmd == CMD_READ && inside_r;

  facr_sum_ram #(.DEPTH(CELLS), .AW(AW), .DW(DW)) u_ram (
    .clk, .wr_en, .wr_addr, .wr_data, .rd_addr, .rd_data
  );

  facr_color #(.SW(SUM_WIDTH)) u_color (
    .clk, .rst_n, .start(col_start), .sum_x(sx), .sum_y(sy), .gain(gain_r),
    .done(col_done), .red(cr), .green(cg), .blue(cb)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      clr_r       <= '0;
      gain_r      <= 16'd256;
      period_r    <= 24'd1000;
      ticks_r     <= '0;
      res_valid_r <= 1'b0;
    end else begin
      if (cfg_valid) begin
        unique case (cfg_index)
          REG_GAIN:   gain_r   <= cfg_data[15:0];
          REG_PERIOD: period_r <= cfg_data;
          default: ;
        endcase
      end
      if (res_valid_r && !out_stall) begin
        res_valid_r <= 1'b0;
      end
      unique case (state_r)
        S_CLEAR: begin
          clr_r <= clr_r + 1'b1;
          if (clr_r == (AW+1)'(CELLS - 1)) begin
            state_r <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (in_valid && in_ok) begin
            req_r    <= in_data;
            inside_r <= inside_in;
            addr_r   <= rd_addr;
            state_r  <= S_READ;
          end
        end
        S_READ: state_r <= S_UPD;
        S_UPD: begin
          if (req_r.cmd == CMD_READ) begin
            res_r <= '{frame_due: 1'b0, out_column: req_r.column,
                       out_row: 7'd127 - req_r.row,
                       red: 8'd255, green: 8'd255, blue: 8'd255};
            if (inside_r) begin
              state_r <= S_COLOR;
            end else begin
              res_valid_r <= 1'b1;
              state_r     <= S_IDLE;
            end
          end else begin
            res_r <= '{frame_due: (req_r.cmd == CMD_EVENT && ticks_r >= period_r),
                       out_column: 7'd0, out_row: 7'd0,
                       red: 8'd0, green: 8'd0, blue: 8'd0};
            if (req_r.cmd == CMD_EVENT && ticks_r >= period_r) begin
              ticks_r <= '0;
            end else if (req_r.cmd == CMD_TICK && ticks_r != 24'hFFFFFF) begin
              ticks_r <= ticks_r + 24'd1;
            end
            res_valid_r <= 1'b1;
            state_r     <= S_IDLE;
          end
        end
        S_COLOR: begin
          if (col_done) begin
            res_r <= '{frame_due: 1'b0, out_column: res_r.out_column,
                       out_row: res_r.out_row, red: cr, green: cg, blue: cb};
            res_valid_r <= 1'b1;
            state_r     <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign out_valid = res_valid_r;
  assign out_data  = res_r;
endmodule

// File: tb/flow_accumulate_color_render_tb.sv
// ----------------------------------------------------------------------------
// flow_accumulate_color_render_tb: self-checking bench for the flow renderer
// Drives events, ticks, readouts and the unused command through bursts and
// gaps, stalls the result side on its own pattern, predicts every result
// from a software copy of the pixel sums and compares field by field.
// ----------------------------------------------------------------------------
module flow_accumulate_color_render_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import facr_pkg::*;

  localparam int  NUM_PIX     = 128 * 128;
  localparam int  CYCLE_LIMIT = 4000000;
  localparam logic [1:0] CMD_UNUSED = 2'd3;

  class flow_scoreboard;
    longint    sum_x[NUM_PIX];
    longint    sum_y[NUM_PIX];
    int unsigned ticks;
    int unsigned gain;
    int unsigned period;
    out_item_t pending_px[$];
    int        errors, n_event, n_tick, n_read, n_frame;

    function new();
      foreach (sum_x[i]) begin
        sum_x[i] = 0;
        sum_y[i] = 0;
      end
      ticks  = 0;
      gain   = 256;
      period = 1000;
    endfunction

    function void set_reg(logic idx, logic [23:0] val);
      if (idx == REG_GAIN) gain = val[15:0];
      else period = val;
    endfunction

    function longint unsigned root(longint unsigned v);
      longint unsigned r, b;
      r = 0;
      b = 64'd1 << 62;
      while (b > v) b >>= 2;
      while (b != 0) begin
        if (v >= r + b) begin
          v -= r + b;
          r = (r >> 1) + b;
        end else r >>= 1;
        b >>= 2;
      end
      return r;
    endfunction

    function longint shift_tz(longint v, int k);
      return v >= 0 ? (v >>> k) : -((-v) >>> k);
    endfunction

    function longint add_sat(longint s, longint v);
      longint r;
      r = s + v;
      if (r > 64'sd2147483647) r = 64'sd2147483647;
      if (r < -64'sd2147483648) r = -64'sd2147483648;
      return r;
    endfunction

    // color wheel lookup from the clipped vector
    function void wheel_color(longint qx, longint qy, ref out_item_t o);
      longint unsigned mag, a, b, c;
      longint x, y, z, off, dx, dy, alfa, f;
      mag = root(4 * (qx * qx + qy * qy));
      if (mag > 255) mag = 255;
      x = qx * 65536;
      y = qy * 65536;
      z = 0;
      off = 0;
      if (x < 0) begin
        off = (y >= 0) ? 98304 : -98304;
        x = -x;
        y = -y;
      end
      for (int i = 0; i < WHEEL_STEPS; i++) begin
        dx = shift_tz(y, i);
        dy = shift_tz(x, i);
        if (y > 0) begin
          x += dx; y -= dy; z += wheel_step(i);
        end else begin
          x -= dx; y += dy; z -= wheel_step(i);
        end
      end
      alfa = 98304 + off + z;
      if (alfa < 0) alfa = 0;
      if (alfa > 196608) alfa = 196608;
      f = alfa < 65536 ? alfa : (alfa < 131072 ? alfa - 65536 : alfa - 131072);
      c = 255 - mag;
      a = c + ((mag * f) >> 16);
      b = c + ((mag * (65536 - f)) >> 16);
      if (alfa < 65536) begin
        o.red = a; o.green = b; o.blue = c;
      end else if (alfa < 131072) begin
        o.red = b; o.green = c; o.blue = a;
      end else begin
        o.red = c; o.green = a; o.blue = b;
      end
    endfunction

    function void pixel_color(longint sx, longint sy, ref out_item_t o);
      longint unsigned ax, ay, qx, qy, len;
      if (sx == 0 && sy == 0) begin
        o.red = 8'hff; o.green = 8'hff; o.blue = 8'hff;
        return;
      end
      ax = (sx < 0 ? -sx : sx) * gain;
      ay = (sy < 0 ? -sy : sy) * gain;
      if (ax < (64'd128 << 16) && ay < (64'd128 << 16) && ax * ax + ay * ay < (64'd1 << 46))
      begin
        qx = ax >> 16;
        qy = ay >> 16;
      end else begin
        while (ax >= (64'd1 << 30) || ay >= (64'd1 << 30)) begin
          ax >>= 1;
          ay >>= 1;
        end
        len = root(ax * ax + ay * ay);
        qx = (ax * 1279) / (10 * len);
        qy = (ay * 1279) / (10 * len);
      end
      wheel_color(sx < 0 ? -longint'(qx) : longint'(qx),
                  sy < 0 ? -longint'(qy) : longint'(qy), o);
    endfunction

    function void note_request(in_item_t it);
      out_item_t o;
      int idx;
      o = '0;
      idx = it.row * 128 + it.column;
      case (it.cmd)
        CMD_EVENT: begin
          n_event++;
          sum_x[idx] = add_sat(sum_x[idx], it.vel_x);
          sum_y[idx] = add_sat(sum_y[idx], it.vel_y);
          if (ticks >= period) begin
            o.frame_due = 1'b1;
            ticks = 0;
            n_frame++;
          end
        end
        CMD_TICK: begin
          n_tick++;
          if (ticks < 24'hffffff) ticks++;
        end
        CMD_READ: begin
          n_read++;
          pixel_color(sum_x[idx], sum_y[idx], o);
          sum_x[idx] = 0;
          sum_y[idx] = 0;
          o.out_column = it.column;
          o.out_row = 7'd127 - it.row;
        end
        default: ;
      endcase
      pending_px.push_back(o);
    endfunction

    function void field(string name, int exp_v, int act_v);
      if (exp_v != act_v) begin
        errors++;
        $display("%0t: %s expected %0d actual %0d", $time, name, exp_v, act_v);
      end
    endfunction

    function void check_result(out_item_t act);
      out_item_t e;
      if (pending_px.size() == 0) begin
        errors++;
        $display("%0t: unexpected result, expected none actual %h", $time, act);
        return;
      end
      e = pending_px.pop_front();
      field("frame_due", e.frame_due, act.frame_due);
      field("out_column", e.out_column, act.out_column);
      field("out_row", e.out_row, act.out_row);
      field("red", e.red, act.red);
      field("green", e.green, act.green);
      field("blue", e.blue, act.blue);
    endfunction
  endclass

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_stall;
  in_item_t    in_data;
  logic        out_valid;
  logic        out_stall;
  out_item_t   out_data;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [0:0]  cfg_index;
  logic [23:0] cfg_data;

  flow_scoreboard sb = new();
  int  cycles;
  bit  hold_req;
  int  hold_left;
  int  stall_mode;
  int  burst_left;
  bit  no_gaps;

  flow_accumulate_color_render DUT (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  initial clk = 1'b0;
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    if (in_valid && !in_stall) sb.note_request(in_data);
    if (out_valid && !out_stall) sb.check_result(out_data);
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("end of test: mismatches");
      $finish;
    end
  end

  // result side stall pattern, with an occasional long hold-off
  always @(posedge clk) begin
    if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      out_stall <= 1'b1;
    end else if (hold_req) begin
      hold_req  <= 1'b0;
      hold_left <= 600;
      out_stall <= 1'b1;
    end else begin
      if ($urandom_range(0, 63) == 0) stall_mode <= $urandom_range(0, 2);
      case (stall_mode)
        0: out_stall <= 1'b0;
        1: out_stall <= ($urandom_range(0, 3) == 0);
        default: out_stall <= ($urandom_range(0, 3) != 0);
      endcase
    end
  end

  task automatic send(in_item_t it);
    in_valid <= 1'b1;
    in_data  <= it;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    if (!no_gaps) begin
      burst_left--;
      if (burst_left <= 0) begin
        burst_left = $urandom_range(1, 40);
        if ($urandom_range(0, 2) != 0) begin
          in_valid <= 1'b0;
          repeat ($urandom_range(1, 12)) @(posedge clk);
        end
      end
    end
  endtask

  task automatic request(logic [1:0] cmd, int col, int row, int vx, int vy);
    in_item_t it;
    it.cmd    = cmd;
    it.column = col;
    it.row    = row;
    it.vel_x  = vx;
    it.vel_y  = vy;
    send(it);
  endtask

  // wait for every expected result, then let the pipeline settle
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (sb.pending_px.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_reg(logic idx, logic [23:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    sb.set_reg(idx, val);
  endtask

  task automatic random_requests(int count);
    int r, col, row, vx, vy;
    logic [1:0] cmd;
    for (int n = 0; n < count; n++) begin
      r = $urandom_range(0, 99);
      cmd = r < 55 ? CMD_EVENT : r < 80 ? CMD_TICK : r < 95 ? CMD_READ : CMD_UNUSED;
      // a small patch keeps sums building up between readouts
      if ($urandom_range(0, 3) != 0) begin
        col = $urandom_range(60, 67);
        row = $urandom_range(0, 7);
      end else begin
        col = $urandom_range(0, 127);
        row = $urandom_range(0, 127);
      end
      if ($urandom_range(0, 1) != 0) begin
        vx = $urandom_range(0, 1024) - 512;
        vy = $urandom_range(0, 1024) - 512;
      end else begin
        vx = $urandom_range(0, 65535);
        vy = $urandom_range(0, 65535);
      end
      request(cmd, col, row, vx, vy);
    end
  endtask

  initial begin
    rst_n      = 1'b0;
    in_valid   = 1'b0;
    in_data    = '0;
    out_stall  = 1'b0;
    cfg_valid  = 1'b0;
    cfg_index  = '0;
    cfg_data   = '0;
    cycles     = 0;
    hold_req   = 1'b0;
    hold_left  = 0;
    stall_mode = 0;
    burst_left = 5;
    no_gaps    = 1'b0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    // directed: reset values first, then extremes
    request(CMD_READ, 3, 3, 0, 0);
    request(CMD_EVENT, 0, 0, 32767, -32768);
    request(CMD_EVENT, 127, 127, -32768, 32767);
    request(CMD_EVENT, 127, 0, 1, 0);
    request(CMD_EVENT, 0, 127, 200, -100);
    request(CMD_EVENT, 0, 127, -200, 100);
    request(CMD_READ, 0, 0, 0, 0);
    request(CMD_READ, 127, 127, 0, 0);
    request(CMD_READ, 127, 0, 0, 0);
    request(CMD_READ, 0, 127, 0, 0);
    request(CMD_UNUSED, 127, 127, -1, -1);
    drain();
    write_reg(REG_PERIOD, 24'd2);
    write_reg(REG_GAIN, 24'd0);
    request(CMD_TICK, 5, 5, 0, 0);
    request(CMD_TICK, 5, 5, 0, 0);
    request(CMD_EVENT, 5, 5, -300, 0);
    request(CMD_EVENT, 5, 5, 0, 0);
    request(CMD_READ, 5, 5, 0, 0);
    drain();
    write_reg(REG_PERIOD, 24'd0);
    write_reg(REG_GAIN, 24'hffffff);
    request(CMD_EVENT, 6, 6, -3, 7);
    request(CMD_EVENT, 6, 7, 0, -1);
    request(CMD_READ, 6, 6, 0, 0);
    request(CMD_READ, 6, 7, 0, 0);
    drain();

    for (int phase = 0; phase < 5; phase++) begin
      case (phase)
        0: begin write_reg(REG_GAIN, 24'd256);   write_reg(REG_PERIOD, 24'd5);  end
        1: begin write_reg(REG_GAIN, 24'd65535); write_reg(REG_PERIOD, 24'd1);  end
        2: begin write_reg(REG_GAIN, 24'd0);     write_reg(REG_PERIOD, 24'd0);  end
        3: begin write_reg(REG_GAIN, 24'd4);     write_reg(REG_PERIOD, 24'hffffff); end
        default: begin
          write_reg(REG_GAIN, $urandom_range(0, 65535));
          write_reg(REG_PERIOD, $urandom_range(1, 30));
        end
      endcase
      random_requests(240);
      if (phase == 1) begin
        // long receiver hold-off while requests keep coming
        hold_req = 1'b1;
        no_gaps = 1'b1;
        random_requests(60);
        no_gaps = 1'b0;
      end
      drain();
    end

    $display("requests: %0d events, %0d ticks, %0d readouts, %0d frames due",
             sb.n_event, sb.n_tick, sb.n_read, sb.n_frame);
    $display("gain and period swept from zero to full scale, long output hold-off included");
    if (sb.errors == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end
endmodule
